[sv/frame_interval_rate_meter_top_macros.svh]
// ----------------------------------------------------------------------------
// frame interval rate meter assertion macros
// property wrappers clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_RATE_METER_TOP_MACROS_SVH
`define FRAME_INTERVAL_RATE_METER_TOP_MACROS_SVH

// same-cycle implication
`define FIM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FIM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fim_pkg.sv]
// ----------------------------------------------------------------------------
// fim_pkg
// shared types and constants of the frame interval rate meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fim_pkg;

	localparam int TIME_W   = 48;
	localparam int DELTA_W  = 20;
	localparam int FRAMES_W = 32;
	localparam int RATE_W   = 22;
	localparam int NUM_W    = 28;
	localparam int CMD_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int Q_DEPTH  = 2;

	localparam int unsigned RATE_NUM = 256000000;
	localparam int unsigned RATE_CAP = 2560000;

	localparam logic [DELTA_W-1:0] MAX_DELTA_RST = 20'd100000;
	localparam logic [DELTA_W-1:0] MIN_DELTA_RST = 20'd100;

	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FRAME = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DELTA = 1'b0,
		REG_MIN_DELTA = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_START  = 4'b0001,
		OP_FRAME  = 4'b0010,
		OP_STOP   = 4'b0100,
		OP_IGNORE = 4'b1000
	} op_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TIME_W-1:0] now_us;
	} item_t;

	typedef struct packed {
		logic                status;
		logic                running;
		logic [DELTA_W-1:0]  delta_us;
		logic [TIME_W-1:0]   elapsed_us;
		logic [FRAMES_W-1:0] frames;
		logic [RATE_W-1:0]   rate_avg;
	} result_t;

	typedef struct packed {
		op_t               op;
		logic              running;
		logic [TIME_W-1:0] now_us;
	} work_t;

endpackage

[sv/fim_queue.sv]
// ----------------------------------------------------------------------------
// fim_queue
// two-entry queue that decouples a producer from a consumer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fim_queue import fim_pkg::*; #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	T                 mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

[sv/fim_front.sv]
// ----------------------------------------------------------------------------
// fim_front
// accepts commands, tracks the enable state and classifies each transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fim_front import fim_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  work_push,
	output work_t work,
	input  logic  work_full
);

	logic  en_q;
	logic  valid_s1;
	work_t work_s1;
	logic  accept;
	op_t   op_c;
	logic  en_c;

	assign work_push = valid_s1;
	assign work      = work_s1;
	assign full      = valid_s1 & work_full;
	assign accept    = push & ~full;

	always_comb begin
		op_c = OP_IGNORE;
		en_c = en_q;
		case (item.command)
			CMD_START: begin
				if (!en_q) begin
					op_c = OP_START;
					en_c = 1'b1;
				end
			end
			CMD_FRAME: begin
				if (en_q) begin
					op_c = OP_FRAME;
				end
			end
			CMD_STOP: begin
				if (en_q) begin
					op_c = OP_STOP;
					en_c = 1'b0;
				end
			end
			default: begin
				op_c = OP_IGNORE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				en_q     <= en_c;
				valid_s1 <= 1'b1;
			end else if (!work_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.op      <= op_c;
			work_s1.running <= en_c;
			work_s1.now_us  <= item.now_us;
		end
	end

endmodule

[sv/fim_div.sv]
// ----------------------------------------------------------------------------
// fim_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fim_div import fim_pkg::*; #(
	parameter int N_W = 28,
	parameter int D_W = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   dvs_q;
	logic [D_W:0]     shifted;
	logic [D_W:0]     diff;
	logic             ge;

	assign shifted  = {rem_q, quo_q[N_W-1]};
	assign diff     = shifted - {1'b0, dvs_q};
	assign ge       = (shifted >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

endmodule

[sv/fim_back.sv]
// ----------------------------------------------------------------------------
// fim_back
// run state, interval and rate arithmetic, rate window and result assembly
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fim_back import fim_pkg::*; #(
	parameter int WINDOW_DEPTH = 60
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELTA_W-1:0]   cfg_data,
	input  work_t                work,
	input  logic                 work_empty,
	output logic                 work_pop,
	output result_t              res,
	output logic                 res_push,
	input  logic                 res_full
);

	localparam int SUM_W  = $clog2(WINDOW_DEPTH * RATE_CAP + 1);
	localparam int DIV_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DELTA  = 9'b000000010,
		S_CLAMP  = 9'b000000100,
		S_SAMPLE = 9'b000001000,
		S_RATE   = 9'b000010000,
		S_SUM    = 9'b000100000,
		S_AVG_GO = 9'b001000000,
		S_AVG    = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic                run_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   start_q;
	logic [TIME_W-1:0]   last_q;
	logic [TIME_W-1:0]   dist_q;
	logic [DELTA_W-1:0]  delta_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RATE_W-1:0]   avg_q;
	logic [RATE_W-1:0]   inst_q;
	logic [RATE_W-1:0]   rd_q;
	logic [DELTA_W-1:0]  max_q;
	logic [DELTA_W-1:0]  min_q;
	logic [RATE_W-1:0]   win_mem [WINDOW_DEPTH];

	logic [TIME_W:0]     diff_last;
	logic [TIME_W:0]     diff_start;
	logic [RATE_W-1:0]   old_rate;
	logic                div_start;
	logic [DIV_W-1:0]    div_dvd;
	logic [DELTA_W-1:0]  div_dvs;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;

	assign diff_last  = {1'b0, now_q} - {1'b0, last_q};
	assign diff_start = {1'b0, now_q} - {1'b0, start_q};
	assign old_rate   = (cnt_q == CNT_W'(WINDOW_DEPTH)) ? rd_q : '0;
	assign work_pop   = (state_q == S_IDLE) & ~work_empty;
	assign res_push   = (state_q == S_EMIT) & ~res_full;
	assign div_start  = (state_q == S_AVG_GO) | ((state_q == S_SAMPLE) & (delta_q > min_q));
	assign div_dvd    = (state_q == S_SAMPLE) ? DIV_W'(RATE_NUM) : DIV_W'(sum_q);
	assign div_dvs    = (state_q == S_SAMPLE) ? delta_q : DELTA_W'(cnt_q);

	always_comb begin
		res.status     = (op_q == OP_IGNORE);
		res.running    = run_q;
		res.delta_us   = run_q ? delta_q : '0;
		res.elapsed_us = run_q ? elapsed_q : '0;
		res.frames     = run_q ? frames_q : '0;
		res.rate_avg   = run_q ? avg_q : '0;
	end

	fim_div #(
		.N_W(DIV_W),
		.D_W(DELTA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_DELTA_RST;
			min_q <= MIN_DELTA_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_DELTA: max_q <= cfg_data;
				REG_MIN_DELTA: min_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_IGNORE;
			run_q     <= 1'b0;
			start_q   <= '0;
			last_q    <= '0;
			delta_q   <= '0;
			elapsed_q <= '0;
			frames_q  <= '0;
			sum_q     <= '0;
			slot_q    <= '0;
			cnt_q     <= '0;
			avg_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!work_empty) begin
						op_q  <= work.op;
						run_q <= work.running;
						case (work.op)
							OP_START: begin
								start_q   <= work.now_us;
								last_q    <= work.now_us;
								delta_q   <= '0;
								elapsed_q <= '0;
								frames_q  <= '0;
								sum_q     <= '0;
								slot_q    <= '0;
								cnt_q     <= '0;
								avg_q     <= '0;
								state_q   <= S_EMIT;
							end
							OP_FRAME: state_q <= S_DELTA;
							default:  state_q <= S_EMIT;
						endcase
					end
				end
				S_DELTA: begin
					elapsed_q <= diff_start[TIME_W] ? '0 : diff_start[TIME_W-1:0];
					last_q    <= now_q;
					frames_q  <= frames_q + FRAMES_W'(1);
					state_q   <= S_CLAMP;
				end
				S_CLAMP: begin
					delta_q <= (dist_q > TIME_W'(max_q)) ? max_q : dist_q[DELTA_W-1:0];
					state_q <= S_SAMPLE;
				end
				S_SAMPLE: begin
					state_q <= (delta_q > min_q) ? S_RATE : S_EMIT;
				end
				S_RATE: begin
					if (div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q <= sum_q - SUM_W'(old_rate) + SUM_W'(inst_q);
					if (cnt_q != CNT_W'(WINDOW_DEPTH)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					slot_q  <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 :
						slot_q + SLOT_W'(1);
					state_q <= S_AVG_GO;
				end
				S_AVG_GO: begin
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (div_done) begin
						avg_q   <= div_quo[RATE_W-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop) begin
			now_q <= work.now_us;
		end
		if (state_q == S_DELTA) begin
			dist_q <= diff_last[TIME_W] ? '0 : diff_last[TIME_W-1:0];
		end
		if ((state_q == S_RATE) && div_done) begin
			inst_q <= (div_quo > DIV_W'(RATE_CAP)) ? RATE_W'(RATE_CAP) : div_quo[RATE_W-1:0];
		end
		if (state_q == S_SUM) begin
			win_mem[slot_q] <= inst_q;
		end
		rd_q <= win_mem[slot_q];
	end

endmodule

[sv/frame_interval_rate_meter_top.sv]
// ----------------------------------------------------------------------------
// frame_interval_rate_meter_top
// result path: start, stop and ignored commands go straight from S_IDLE to S_EMIT;
//   a frame passes S_DELTA, S_CLAMP and S_SAMPLE, then S_RATE to S_AVG if it is sampled
// back end: one transaction at a time; a sampled frame makes two 28-step divisions
//   on one divider, for the instant rate and for the window average
// reset: arst_n clears enable state, queues, counters and control registers at once;
//   the rate window is tracked by a fill count and needs no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_interval_rate_meter_top import fim_pkg::*; #(
	parameter int WINDOW_DEPTH = 60
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  item_t                item,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELTA_W-1:0]   cfg_data
);

	logic    fw_push;
	work_t   fw_work;
	logic    fw_full;
	logic    wb_pop;
	work_t   wb_work;
	logic    wb_empty;
	logic    rs_push;
	result_t rs_res;
	logic    rs_full;

	assign cfg_ready = 1'b1;

	fim_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.work_push (fw_push),
		.work      (fw_work),
		.work_full (fw_full)
	);

	fim_queue #(
		.T(work_t)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fw_push),
		.din    (fw_work),
		.full   (fw_full),
		.pop    (wb_pop),
		.dout   (wb_work),
		.empty  (wb_empty)
	);

	fim_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.work       (wb_work),
		.work_empty (wb_empty),
		.work_pop   (wb_pop),
		.res        (rs_res),
		.res_push   (rs_push),
		.res_full   (rs_full)
	);

	fim_queue #(
		.T(result_t)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rs_push),
		.din    (rs_res),
		.full   (rs_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule

[sv/fim_checker.sv]
// ----------------------------------------------------------------------------
// fim_checker
// port-level checks on the result side of the frame interval rate meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_interval_rate_meter_top_macros.svh"

module fim_checker import fim_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	`FIM_ASSERT_NOW(a_idle_zero, !empty && !result.running, result.delta_us == '0 && result.elapsed_us == '0 && result.frames == '0 && result.rate_avg == '0, "stopped result carries nonzero stats")

	`FIM_ASSERT_NOW(a_rate_cap, !empty, result.rate_avg <= RATE_W'(RATE_CAP), "average rate above cap")

	`FIM_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

bind frame_interval_rate_meter_top fim_checker u_fim_checker (.*);
